// File: hdl/ffsa_pkg.sv
package ffsa_pkg;

   localparam int OFF_W  = 16;
   localparam int LEN_W  = 17;
   localparam int ADDR_W = 2;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_REALLOC = 2'd2;
   localparam logic [1:0] CMD_DEFRAG  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOMEM   = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [ADDR_W-1:0] REG_ARENA_SIZE = 2'd0;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [LEN_W-1:0] size;
      logic             free;
   } seg_type;

   localparam int SEG_W = OFF_W + LEN_W + 1;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] new_off;
      logic [OFF_W-1:0] old_off;
      logic             moved;
   } res_type;

   typedef struct packed {
      logic             init;
      logic [LEN_W-1:0] arena;
   } cfg_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_FIND_RD, S_FIND_CHK, S_FIT_RD, S_FIT_CHK, S_TAKE, S_TAKE_WR,
      S_INS_RD, S_INS_WR, S_RM_RD, S_RM_WR, S_REL_NRD, S_REL_NCHK, S_REL_PRD,
      S_REL_PCHK, S_REL_WR, S_RA, S_RA_NRD, S_RA_NCHK, S_RA_DO, S_RA_WR,
      S_DF_RD, S_DF_CHK, S_DF_END, S_RESP
   } state_type;

endpackage

// File: hdl/ffsa_ram.sv
module ffsa_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/ffsa_seq.sv
module ffsa_seq #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ffsa_pkg::cfg_type cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,
   input  logic [39:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [1:0]        rsp_tuser,
   output logic [39:0]       rsp_tdata,
   output logic              rsp_tlast
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   ffsa_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [15:0]   off_ff, off_in;
   logic [16:0]   len_ff, len_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in, cur_idx_ff, cur_idx_in, fit_idx_ff, fit_idx_in;
   logic [IW-1:0] sh_ff, sh_in, pos_ff, pos_in;
   logic [1:0]    gap_ff, gap_in;
   logic          split_ff, split_in, nfree_ff, nfree_in, pfree_ff, pfree_in;
   ffsa_pkg::seg_type cur_ff, cur_in, fit_ff, fit_in, nxt_ff, nxt_in, prv_ff, prv_in;
   ffsa_pkg::seg_type ins_ff, ins_in;
   logic [CW-1:0] w_ff, w_in;
   logic [16:0]   acc_ff, acc_in, spare_ff, spare_in;
   logic [15:0]   dq_new_ff, dq_new_in, dq_old_ff, dq_old_in;
   logic          dq_ok_ff, dq_ok_in;
   ffsa_pkg::res_type fin_ff, fin_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;

   logic              mem_we;
   logic [IW-1:0]     mem_waddr, mem_raddr;
   ffsa_pkg::seg_type mem_wdata, rd;
   logic [ffsa_pkg::SEG_W-1:0] ram_rdata;

   logic        emit_ok, idx_more, cur_has_next, has_prev, full, fit_hit, used_hit;
   logic        split, shrink, same, grow_fits, reloc, df_stall, ins_more, rm_more;
   logic [16:0] d_shr, d_grw, rel_size, req_len;

   ffsa_ram #(.WIDTH(ffsa_pkg::SEG_W), .DEPTH(MAX_SEGMENTS)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (ram_rdata)
   );

   assign rd           = ffsa_pkg::seg_type'(ram_rdata);
   assign req_len      = req_tdata[32:16];
   assign emit_ok      = !rsp_valid_ff || rsp_tready;
   assign idx_more     = (CW'(idx_ff) + CW'(1)) < count_ff;
   assign cur_has_next = (CW'(cur_idx_ff) + CW'(1)) < count_ff;
   assign has_prev     = cur_idx_ff != '0;
   assign full         = count_ff >= CW'(MAX_SEGMENTS);
   assign fit_hit      = rd.free && (rd.size >= len_ff);
   assign used_hit     = rd.start == off_ff;
   assign split        = fit_ff.size > len_ff;
   assign shrink       = len_ff < cur_ff.size;
   assign same         = len_ff == cur_ff.size;
   assign d_shr        = cur_ff.size - len_ff;
   assign d_grw        = len_ff - cur_ff.size;
   assign grow_fits    = nfree_ff && (nxt_ff.size >= d_grw);
   assign rel_size     = cur_ff.size + (nfree_ff ? nxt_ff.size : 17'd0);
   assign reloc        = {1'b0, rd.start} != acc_ff;
   assign df_stall     = !rd.free && reloc && dq_ok_ff && !emit_ok;
   assign ins_more     = sh_ff > pos_ff;
   assign rm_more      = ((CW+1)'(sh_ff) + (CW+1)'(gap_ff)) < (CW+1)'(count_ff);

   assign req_tready = state_ff == ffsa_pkg::S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.moved, rsp_ff.old_off, rsp_ff.new_off};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffsa_pkg::S_INIT: state_in = ffsa_pkg::S_IDLE;
         ffsa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  ffsa_pkg::CMD_ALLOC:
                     state_in = (req_len == '0) ? ffsa_pkg::S_RESP : ffsa_pkg::S_FIT_RD;
                  ffsa_pkg::CMD_FREE, ffsa_pkg::CMD_REALLOC: state_in = ffsa_pkg::S_FIND_RD;
                  default: state_in = ffsa_pkg::S_DF_RD;
               endcase
            end
         end
         ffsa_pkg::S_FIND_RD: state_in = ffsa_pkg::S_FIND_CHK;
         ffsa_pkg::S_FIND_CHK: begin
            if (used_hit) begin
               if (rd.free) state_in = ffsa_pkg::S_RESP;
               else if (cmd_ff == ffsa_pkg::CMD_FREE) state_in = ffsa_pkg::S_REL_NRD;
               else state_in = ffsa_pkg::S_RA;
            end else begin
               state_in = idx_more ? ffsa_pkg::S_FIND_RD : ffsa_pkg::S_RESP;
            end
         end
         ffsa_pkg::S_FIT_RD: state_in = ffsa_pkg::S_FIT_CHK;
         ffsa_pkg::S_FIT_CHK: begin
            if (fit_hit) state_in = ffsa_pkg::S_TAKE;
            else state_in = idx_more ? ffsa_pkg::S_FIT_RD : ffsa_pkg::S_RESP;
         end
         ffsa_pkg::S_TAKE: begin
            if (split) state_in = full ? ffsa_pkg::S_RESP : ffsa_pkg::S_INS_RD;
            else state_in = ffsa_pkg::S_TAKE_WR;
         end
         ffsa_pkg::S_TAKE_WR:
            state_in = (cmd_ff == ffsa_pkg::CMD_ALLOC) ? ffsa_pkg::S_RESP : ffsa_pkg::S_REL_NRD;
         ffsa_pkg::S_INS_RD: state_in = ins_more ? ffsa_pkg::S_INS_WR : ret_ff;
         ffsa_pkg::S_INS_WR: state_in = ffsa_pkg::S_INS_RD;
         ffsa_pkg::S_RM_RD: state_in = rm_more ? ffsa_pkg::S_RM_WR : ret_ff;
         ffsa_pkg::S_RM_WR: state_in = ffsa_pkg::S_RM_RD;
         ffsa_pkg::S_REL_NRD:
            state_in = cur_has_next ? ffsa_pkg::S_REL_NCHK : ffsa_pkg::S_REL_PRD;
         ffsa_pkg::S_REL_NCHK: state_in = ffsa_pkg::S_REL_PRD;
         ffsa_pkg::S_REL_PRD: state_in = has_prev ? ffsa_pkg::S_REL_PCHK : ffsa_pkg::S_REL_WR;
         ffsa_pkg::S_REL_PCHK: state_in = ffsa_pkg::S_REL_WR;
         ffsa_pkg::S_REL_WR:
            state_in = (pfree_ff || nfree_ff) ? ffsa_pkg::S_RM_RD : ffsa_pkg::S_RESP;
         ffsa_pkg::S_RA:
            state_in = (len_ff == '0 || same) ? ffsa_pkg::S_RESP : ffsa_pkg::S_RA_NRD;
         ffsa_pkg::S_RA_NRD:
            state_in = cur_has_next ? ffsa_pkg::S_RA_NCHK : ffsa_pkg::S_RA_DO;
         ffsa_pkg::S_RA_NCHK: state_in = ffsa_pkg::S_RA_DO;
         ffsa_pkg::S_RA_DO: begin
            if (shrink) begin
               if (nfree_ff) state_in = ffsa_pkg::S_RA_WR;
               else state_in = full ? ffsa_pkg::S_RESP : ffsa_pkg::S_INS_RD;
            end else if (grow_fits) begin
               state_in = (nxt_ff.size == d_grw) ? ffsa_pkg::S_RM_RD : ffsa_pkg::S_RA_WR;
            end else begin
               state_in = ffsa_pkg::S_FIT_RD;
            end
         end
         ffsa_pkg::S_RA_WR: state_in = ffsa_pkg::S_RESP;
         ffsa_pkg::S_DF_RD: state_in = ffsa_pkg::S_DF_CHK;
         ffsa_pkg::S_DF_CHK: begin
            if (!df_stall) state_in = idx_more ? ffsa_pkg::S_DF_RD : ffsa_pkg::S_DF_END;
         end
         ffsa_pkg::S_DF_END: state_in = ffsa_pkg::S_RESP;
         ffsa_pkg::S_RESP: state_in = emit_ok ? ffsa_pkg::S_IDLE : ffsa_pkg::S_RESP;
         default: state_in = ffsa_pkg::S_INIT;
      endcase
      if (cfg.init) state_in = ffsa_pkg::S_INIT;
   end

   always_comb begin
      ret_in = ret_ff;    cmd_in = cmd_ff;     off_in = off_ff;     len_in = len_ff;
      count_in = count_ff; idx_in = idx_ff;    cur_idx_in = cur_idx_ff;
      fit_idx_in = fit_idx_ff; sh_in = sh_ff;  pos_in = pos_ff;     gap_in = gap_ff;
      split_in = split_ff; nfree_in = nfree_ff; pfree_in = pfree_ff;
      cur_in = cur_ff;     fit_in = fit_ff;     nxt_in = nxt_ff;     prv_in = prv_ff;
      ins_in = ins_ff;     w_in = w_ff;         acc_in = acc_ff;     spare_in = spare_ff;
      dq_new_in = dq_new_ff; dq_old_in = dq_old_ff; dq_ok_in = dq_ok_ff;
      fin_in = fin_ff;     rsp_in = rsp_ff;     rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we = 1'b0;       mem_waddr = '0;      mem_wdata = '0;      mem_raddr = idx_ff;
      unique case (state_ff)
         ffsa_pkg::S_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = '{start: '0, size: cfg.arena, free: 1'b1};
            count_in  = CW'(1);
         end
         ffsa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               off_in   = req_tdata[15:0];
               len_in   = req_len;
               idx_in   = '0;
               w_in     = '0;
               acc_in   = '0;
               spare_in = '0;
               dq_ok_in = 1'b0;
               fin_in   = '0;
               if (req_tuser == ffsa_pkg::CMD_ALLOC && req_len == '0) begin
                  fin_in.status = ffsa_pkg::ST_NOMEM;
               end
            end
         end
         ffsa_pkg::S_FIND_RD, ffsa_pkg::S_FIT_RD, ffsa_pkg::S_DF_RD: mem_raddr = idx_ff;
         ffsa_pkg::S_FIND_CHK: begin
            if (used_hit) begin
               if (rd.free) begin
                  fin_in.status = ffsa_pkg::ST_BADFREE;
               end else begin
                  cur_in     = rd;
                  cur_idx_in = idx_ff;
               end
            end else if (idx_more) begin
               idx_in = idx_ff + IW'(1);
            end else begin
               fin_in.status = ffsa_pkg::ST_BADFREE;
            end
         end
         ffsa_pkg::S_FIT_CHK: begin
            if (fit_hit) begin
               fit_in     = rd;
               fit_idx_in = idx_ff;
            end else if (idx_more) begin
               idx_in = idx_ff + IW'(1);
            end else begin
               fin_in.status = ffsa_pkg::ST_NOMEM;
            end
         end
         ffsa_pkg::S_TAKE: begin
            split_in = split;
            if (split) begin
               if (full) begin
                  fin_in.status = ffsa_pkg::ST_FULL;
               end else begin
                  pos_in = fit_idx_ff + IW'(1);
                  sh_in  = count_ff[IW-1:0];
                  ins_in = '{start: fit_ff.start + len_ff[15:0], size: fit_ff.size - len_ff,
                             free: 1'b1};
                  ret_in = ffsa_pkg::S_TAKE_WR;
               end
            end
         end
         ffsa_pkg::S_TAKE_WR: begin
            mem_we    = 1'b1;
            mem_waddr = fit_idx_ff;
            mem_wdata = '{start: fit_ff.start, size: len_ff, free: 1'b0};
            if (cmd_ff == ffsa_pkg::CMD_ALLOC) begin
               fin_in.new_off = fit_ff.start;
            end else if (split_ff && fit_idx_ff < cur_idx_ff) begin
               cur_idx_in = cur_idx_ff + IW'(1);
            end
         end
         ffsa_pkg::S_INS_RD: begin
            if (ins_more) begin
               mem_raddr = sh_ff - IW'(1);
            end else begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff;
               mem_wdata = ins_ff;
               count_in  = count_ff + CW'(1);
            end
         end
         ffsa_pkg::S_INS_WR: begin
            mem_we    = 1'b1;
            mem_waddr = sh_ff;
            mem_wdata = rd;
            sh_in     = sh_ff - IW'(1);
         end
         ffsa_pkg::S_RM_RD: begin
            if (rm_more) mem_raddr = sh_ff + IW'(gap_ff);
            else count_in = count_ff - CW'(gap_ff);
         end
         ffsa_pkg::S_RM_WR: begin
            mem_we    = 1'b1;
            mem_waddr = sh_ff;
            mem_wdata = rd;
            sh_in     = sh_ff + IW'(1);
         end
         ffsa_pkg::S_REL_NRD, ffsa_pkg::S_RA_NRD: begin
            nfree_in  = 1'b0;
            mem_raddr = cur_idx_ff + IW'(1);
         end
         ffsa_pkg::S_REL_NCHK, ffsa_pkg::S_RA_NCHK: begin
            nxt_in   = rd;
            nfree_in = rd.free;
         end
         ffsa_pkg::S_REL_PRD: begin
            pfree_in  = 1'b0;
            mem_raddr = cur_idx_ff - IW'(1);
         end
         ffsa_pkg::S_REL_PCHK: begin
            prv_in   = rd;
            pfree_in = rd.free;
         end
         ffsa_pkg::S_REL_WR: begin
            mem_we = 1'b1;
            ret_in = ffsa_pkg::S_RESP;
            if (pfree_ff) begin
               mem_waddr = cur_idx_ff - IW'(1);
               mem_wdata = '{start: prv_ff.start, size: prv_ff.size + rel_size, free: 1'b1};
               sh_in     = cur_idx_ff;
               gap_in    = nfree_ff ? 2'd2 : 2'd1;
            end else begin
               mem_waddr = cur_idx_ff;
               mem_wdata = '{start: cur_ff.start, size: rel_size, free: 1'b1};
               sh_in     = cur_idx_ff + IW'(1);
               gap_in    = 2'd1;
            end
            if (cmd_ff != ffsa_pkg::CMD_FREE) begin
               fin_in.new_off = fit_ff.start;
               fin_in.old_off = off_ff;
               fin_in.moved   = 1'b1;
            end
         end
         ffsa_pkg::S_RA: begin
            if (len_ff == '0) fin_in.status = ffsa_pkg::ST_NOMEM;
            else if (same) fin_in.new_off = cur_ff.start;
         end
         ffsa_pkg::S_RA_DO: begin
            if (shrink) begin
               if (nfree_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_idx_ff + IW'(1);
                  mem_wdata = '{start: nxt_ff.start - d_shr[15:0], size: nxt_ff.size + d_shr,
                                free: 1'b1};
               end else if (full) begin
                  fin_in.status = ffsa_pkg::ST_FULL;
               end else begin
                  pos_in = cur_idx_ff + IW'(1);
                  sh_in  = count_ff[IW-1:0];
                  ins_in = '{start: cur_ff.start + len_ff[15:0], size: d_shr, free: 1'b1};
                  ret_in = ffsa_pkg::S_RA_WR;
               end
            end else if (grow_fits) begin
               if (nxt_ff.size == d_grw) begin
                  sh_in  = cur_idx_ff + IW'(1);
                  gap_in = 2'd1;
                  ret_in = ffsa_pkg::S_RA_WR;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_idx_ff + IW'(1);
                  mem_wdata = '{start: nxt_ff.start + d_grw[15:0], size: nxt_ff.size - d_grw,
                                free: 1'b1};
               end
            end else begin
               idx_in = '0;
            end
         end
         ffsa_pkg::S_RA_WR: begin
            mem_we         = 1'b1;
            mem_waddr      = cur_idx_ff;
            mem_wdata      = '{start: cur_ff.start, size: len_ff, free: 1'b0};
            fin_in.new_off = cur_ff.start;
         end
         ffsa_pkg::S_DF_CHK: begin
            if (rd.free) begin
               spare_in = spare_ff + rd.size;
            end else if (!df_stall) begin
               if (reloc) begin
                  if (dq_ok_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ffsa_pkg::ST_OK, new_off: dq_new_ff,
                                      old_off: dq_old_ff, moved: 1'b1};
                     rsp_last_in  = 1'b0;
                  end
                  dq_new_in = acc_ff[15:0];
                  dq_old_in = rd.start;
                  dq_ok_in  = 1'b1;
               end
               mem_we    = 1'b1;
               mem_waddr = w_ff[IW-1:0];
               mem_wdata = '{start: acc_ff[15:0], size: rd.size, free: 1'b0};
               acc_in    = acc_ff + rd.size;
               w_in      = w_ff + CW'(1);
            end
            if (!df_stall && idx_more) idx_in = idx_ff + IW'(1);
         end
         ffsa_pkg::S_DF_END: begin
            if (spare_ff != '0 && w_ff < CW'(MAX_SEGMENTS)) begin
               mem_we    = 1'b1;
               mem_waddr = w_ff[IW-1:0];
               mem_wdata = '{start: acc_ff[15:0], size: spare_ff, free: 1'b1};
               count_in  = w_ff + CW'(1);
            end else begin
               count_in = w_ff;
            end
            if (dq_ok_ff) begin
               fin_in = '{status: ffsa_pkg::ST_OK, new_off: dq_new_ff, old_off: dq_old_ff,
                          moved: 1'b1};
            end
         end
         ffsa_pkg::S_RESP: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_in       = fin_ff;
               rsp_last_in  = 1'b1;
            end
         end
         default: mem_raddr = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffsa_pkg::S_INIT;
         count_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff <= ret_in;      cmd_ff <= cmd_in;      off_ff <= off_in;    len_ff <= len_in;
      idx_ff <= idx_in;      cur_idx_ff <= cur_idx_in; fit_idx_ff <= fit_idx_in;
      sh_ff <= sh_in;        pos_ff <= pos_in;      gap_ff <= gap_in;
      split_ff <= split_in;  nfree_ff <= nfree_in;  pfree_ff <= pfree_in;
      cur_ff <= cur_in;      fit_ff <= fit_in;      nxt_ff <= nxt_in;    prv_ff <= prv_in;
      ins_ff <= ins_in;      w_ff <= w_in;          acc_ff <= acc_in;    spare_ff <= spare_in;
      dq_new_ff <= dq_new_in; dq_old_ff <= dq_old_in; dq_ok_ff <= dq_ok_in;
      fin_ff <= fin_in;      rsp_ff <= rsp_in;      rsp_last_ff <= rsp_last_in;
   end

endmodule

// File: hdl/first_fit_segment_allocator_top.sv
// Channel  | Direction | Ports  | Contents
// req      | in        | req_*  | command, block offset, length
// rsp      | out       | rsp_*  | status, new/old offset, moved, last
// csr      | in/out    | csr_*  | arena size register (APB)
//
// The segment table lives in one single-port-write RAM with a registered read, so every
// scan, shift or compaction pass visits the table one entry at a time. Reset and each
// arena size write rewrite entry 0. A full result register stalls the command in its
// last state, and stalls defrag at the next relocation.
module first_fit_segment_allocator_top #(
   parameter int ARENA_BYTES  = 65536,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // command
   input  logic [39:0] req_tdata,   // block_offset[15:0], length[32:16], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [39:0] rsp_tdata,   // new_off[15:0], old_offset[31:16], moved[32], zero fill
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [ffsa_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [16:0] ARENA_LIMIT = (ARENA_BYTES < 65536) ? 17'(ARENA_BYTES) : 17'd65536;

   logic [16:0]       arena_ff, arena_in, wr_val;
   logic              csr_wr, reg_wr;
   ffsa_pkg::cfg_type cfg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_wr     = csr_wr && (csr_paddr == ffsa_pkg::REG_ARENA_SIZE);
   assign csr_prdata = {15'd0, arena_ff};

   always_comb begin
      wr_val = csr_pwdata[16:0];
      if (wr_val == '0) wr_val = 17'd1;
      else if (wr_val > ARENA_LIMIT) wr_val = ARENA_LIMIT;
      arena_in = reg_wr ? wr_val : arena_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_ff <= ARENA_LIMIT;
      end else begin
         arena_ff <= arena_in;
      end
   end

   assign cfg = '{init: reg_wr, arena: arena_ff};

   ffsa_seq #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      reg_wr |=> !req_tready)
      else $error("request accepted during table rebuild");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ffsa_pkg::ST_OK) |-> rsp_tlast)
      else $error("error result not final");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ffsa_pkg::ST_OK) |-> (rsp_tdata == '0))
      else $error("error result carries offsets");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int NSEG = 64;
   localparam int ARENA_MAX = 65536;
   localparam int LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [ffsa_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   first_fit_segment_allocator_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct {
      logic [1:0]  status;
      logic [15:0] new_off;
      logic [15:0] old_off;
      logic        moved;
      logic        last;
   } alloc_result_type;

   alloc_result_type pending_results[$];

   int unsigned seg_start[NSEG];
   int unsigned seg_size[NSEG];
   bit          seg_free[NSEG];
   int unsigned seg_count;
   int unsigned arena_bytes;

   int  mismatches = 0;
   int  cycles = 0;
   bit  quiet_mode = 0;

   function automatic void table_reset();
      for (int k = 0; k < NSEG; k++) begin
         seg_start[k] = 0; seg_size[k] = 0; seg_free[k] = 0;
      end
      seg_size[0] = arena_bytes;
      seg_free[0] = 1;
      seg_count = 1;
   endfunction

   function automatic void seg_remove(int unsigned i);
      for (int unsigned k = i; k + 1 < seg_count; k++) begin
         seg_start[k] = seg_start[k+1]; seg_size[k] = seg_size[k+1];
         seg_free[k] = seg_free[k+1];
      end
      seg_count--;
   endfunction

   function automatic void seg_insert(int unsigned i, int unsigned s, int unsigned n, bit f);
      for (int unsigned k = seg_count; k > i; k--) begin
         seg_start[k] = seg_start[k-1]; seg_size[k] = seg_size[k-1];
         seg_free[k] = seg_free[k-1];
      end
      seg_start[i] = s; seg_size[i] = n; seg_free[i] = f;
      seg_count++;
   endfunction

   function automatic int find_used(int unsigned off);
      for (int unsigned i = 0; i < seg_count; i++)
         if (seg_start[i] == off) return seg_free[i] ? -1 : int'(i);
      return -1;
   endfunction

   function automatic int first_fit(int unsigned n);
      for (int unsigned i = 0; i < seg_count; i++)
         if (seg_free[i] && seg_size[i] >= n) return int'(i);
      return -1;
   endfunction

   function automatic bit seg_take(int unsigned i, int unsigned n);
      if (seg_size[i] > n) begin
         if (seg_count >= NSEG) return 0;
         seg_insert(i + 1, seg_start[i] + n, seg_size[i] - n, 1);
         seg_size[i] = n;
      end
      seg_free[i] = 0;
      return 1;
   endfunction

   function automatic void seg_release(int unsigned i);
      seg_free[i] = 1;
      if (i + 1 < seg_count && seg_free[i+1]) begin
         seg_size[i] += seg_size[i+1];
         seg_remove(i + 1);
      end
      if (i > 0 && seg_free[i-1]) begin
         seg_size[i-1] += seg_size[i];
         seg_remove(i);
      end
   endfunction

   function automatic void push_result(logic [1:0] st, int unsigned nw, int unsigned od,
                                       bit mv, bit lst);
      alloc_result_type r;
      r.status = st; r.new_off = nw[15:0]; r.old_off = od[15:0];
      r.moved = mv; r.last = lst;
      pending_results.push_back(r);
   endfunction

   function automatic void predict_realloc(int unsigned off, int unsigned n);
      int f, g;
      int unsigned i, d, k, cnt, nw;
      f = find_used(off);
      if (f < 0) begin push_result(ffsa_pkg::ST_BADFREE, 0, 0, 0, 1); return; end
      i = f;
      if (n == 0) begin push_result(ffsa_pkg::ST_NOMEM, 0, 0, 0, 1); return; end
      if (n < seg_size[i]) begin
         d = seg_size[i] - n;
         if (i + 1 < seg_count && seg_free[i+1]) begin
            seg_start[i+1] -= d;
            seg_size[i+1] += d;
         end else begin
            if (seg_count >= NSEG) begin
               push_result(ffsa_pkg::ST_FULL, 0, 0, 0, 1);
               return;
            end
            seg_insert(i + 1, seg_start[i] + n, d, 1);
         end
         seg_size[i] = n;
      end else if (n > seg_size[i]) begin
         d = n - seg_size[i];
         if (i + 1 < seg_count && seg_free[i+1] && seg_size[i+1] >= d) begin
            if (seg_size[i+1] == d) seg_remove(i + 1);
            else begin
               seg_start[i+1] += d;
               seg_size[i+1] -= d;
            end
            seg_size[i] = n;
         end else begin
            g = first_fit(n);
            if (g < 0) begin push_result(ffsa_pkg::ST_NOMEM, 0, 0, 0, 1); return; end
            k = g;
            cnt = seg_count;
            if (!seg_take(k, n)) begin push_result(ffsa_pkg::ST_FULL, 0, 0, 0, 1); return; end
            if (seg_count != cnt && k < i) i++;
            nw = seg_start[k];
            seg_release(i);
            push_result(ffsa_pkg::ST_OK, nw, off, 1, 1);
            return;
         end
      end
      push_result(ffsa_pkg::ST_OK, seg_start[i], 0, 0, 1);
   endfunction

   function automatic void predict_defrag();
      int unsigned w = 0, off = 0, spare = 0, moves = 0;
      for (int unsigned r = 0; r < seg_count; r++) begin
         if (seg_free[r]) begin
            spare += seg_size[r];
            continue;
         end
         if (seg_start[r] != off) begin
            push_result(ffsa_pkg::ST_OK, off, seg_start[r], 1, 0);
            moves++;
         end
         seg_start[w] = off; seg_size[w] = seg_size[r]; seg_free[w] = 0;
         off += seg_size[r];
         w++;
      end
      if (spare != 0 && w < NSEG) begin
         seg_start[w] = off; seg_size[w] = spare; seg_free[w] = 1;
         w++;
      end
      seg_count = w;
      if (moves == 0) push_result(ffsa_pkg::ST_OK, 0, 0, 0, 1);
      else pending_results[$].last = 1;
   endfunction

   function automatic void predict_command(logic [1:0] cmd, int unsigned off, int unsigned n);
      int f;
      case (cmd)
         ffsa_pkg::CMD_ALLOC: begin
            f = (n == 0) ? -1 : first_fit(n);
            if (f < 0) push_result(ffsa_pkg::ST_NOMEM, 0, 0, 0, 1);
            else if (!seg_take(f, n)) push_result(ffsa_pkg::ST_FULL, 0, 0, 0, 1);
            else push_result(ffsa_pkg::ST_OK, seg_start[f], 0, 0, 1);
         end
         ffsa_pkg::CMD_FREE: begin
            f = find_used(off);
            if (f < 0) push_result(ffsa_pkg::ST_BADFREE, 0, 0, 0, 1);
            else begin
               seg_release(f);
               push_result(ffsa_pkg::ST_OK, 0, 0, 0, 1);
            end
         end
         ffsa_pkg::CMD_REALLOC: predict_realloc(off, n);
         default: predict_defrag();
      endcase
   endfunction

   function automatic bit idle_now();
      return !quiet_mode && ($urandom_range(99) < 7);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("first_fit_segment_allocator_top verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer status=%0d", rsp_tuser);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tuser !== exp_r.status || rsp_tdata[15:0] !== exp_r.new_off ||
                rsp_tdata[31:16] !== exp_r.old_off || rsp_tdata[32] !== exp_r.moved ||
                rsp_tlast !== exp_r.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %h %h %b %b, got %0d %h %h %b %b",
                           exp_r.status, exp_r.new_off, exp_r.old_off, exp_r.moved, exp_r.last,
                           rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[32],
                           rsp_tlast);
            end
         end
      end
   end

   always @(negedge clock) rsp_tready <= !reset && !idle_now();

   task automatic send_command(logic [1:0] cmd, int unsigned off, int unsigned n);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, n[16:0], off[15:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_command(cmd, off, n);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8 * NSEG + 40) @(negedge clock);
   endtask

   task automatic write_arena(int unsigned value);
      int unsigned v;
      wait_drained();
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= ffsa_pkg::REG_ARENA_SIZE;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      v = value & 32'h1FFFF;
      if (v == 0) v = 1;
      if (v > ARENA_MAX) v = ARENA_MAX;
      arena_bytes = v;
      table_reset();
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      repeat (4) @(negedge clock);
   endtask

   function automatic int unsigned pick_used_offset();
      int unsigned cand[$];
      for (int unsigned i = 0; i < seg_count; i++) if (!seg_free[i]) cand.push_back(seg_start[i]);
      if (cand.size() == 0) return $urandom_range(65535);
      return cand[$urandom_range(cand.size() - 1)];
   endfunction

   task automatic test_directed();
      send_command(ffsa_pkg::CMD_ALLOC, 0, 0);
      send_command(ffsa_pkg::CMD_ALLOC, 16'hFFFF, 65536);
      send_command(ffsa_pkg::CMD_FREE, 0, 0);
      send_command(ffsa_pkg::CMD_DEFRAG, 0, 0);
      send_command(ffsa_pkg::CMD_FREE, 0, 0);
      send_command(ffsa_pkg::CMD_ALLOC, 0, 100);
      send_command(ffsa_pkg::CMD_ALLOC, 0, 200);
      send_command(ffsa_pkg::CMD_ALLOC, 0, 300);
      send_command(ffsa_pkg::CMD_ALLOC, 0, 65536);
      send_command(ffsa_pkg::CMD_FREE, 100, 0);
      send_command(ffsa_pkg::CMD_FREE, 100, 0);
      send_command(ffsa_pkg::CMD_REALLOC, 0, 100);
      send_command(ffsa_pkg::CMD_REALLOC, 0, 0);
      send_command(ffsa_pkg::CMD_REALLOC, 0, 250);
      send_command(ffsa_pkg::CMD_REALLOC, 0, 500);
      send_command(ffsa_pkg::CMD_REALLOC, 300, 50);
      send_command(ffsa_pkg::CMD_REALLOC, 777, 5);
      send_command(ffsa_pkg::CMD_DEFRAG, 0, 0);
      send_command(ffsa_pkg::CMD_REALLOC, 0, 131071);
      send_command(ffsa_pkg::CMD_DEFRAG, 0, 0);
   endtask

   task automatic test_table_full();
      write_arena(70);
      for (int i = 0; i < 66; i++) send_command(ffsa_pkg::CMD_ALLOC, 0, 1);
      send_command(ffsa_pkg::CMD_FREE, 3, 0);
      send_command(ffsa_pkg::CMD_FREE, 5, 0);
      send_command(ffsa_pkg::CMD_REALLOC, 4, 1);
      send_command(ffsa_pkg::CMD_REALLOC, 10, 0);
      send_command(ffsa_pkg::CMD_DEFRAG, 0, 0);
   endtask

   task automatic test_random(int count, int unsigned arena);
      int unsigned r, n;
      logic [1:0] cmd;
      write_arena(arena);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         cmd = (r < 40) ? ffsa_pkg::CMD_ALLOC : (r < 70) ? ffsa_pkg::CMD_FREE :
               (r < 94) ? ffsa_pkg::CMD_REALLOC : ffsa_pkg::CMD_DEFRAG;
         n = ($urandom_range(19) == 0) ? $urandom_range(131071) :
             $urandom_range((arena / 8) + 1);
         if ($urandom_range(9) == 0)
            send_command(cmd, $urandom_range(65535), n);
         else
            send_command(cmd, pick_used_offset(), n);
      end
   endtask

   initial begin
      arena_bytes = ARENA_MAX;
      table_reset();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(negedge clock);
      test_directed();
      test_table_full();
      test_random(100, 4096);
      quiet_mode = 1;
      test_random(100, 1);
      quiet_mode = 0;
      test_random(100, 65536);
      test_random(70, 32'h0001_FFFF);
      test_random(20, 0);
      wait_drained();
      if (mismatches == 0 && pending_results.size() == 0)
         $display("first_fit_segment_allocator_top verification clean");
      else
         $display("first_fit_segment_allocator_top verification failed");
      $finish;
   end
endmodule

// File: sim.f
hdl/ffsa_pkg.sv
hdl/ffsa_ram.sv
hdl/ffsa_seq.sv
hdl/first_fit_segment_allocator_top.sv
verif/tb.sv
